// ===== src/gsw_pkg.sv =====
// Shared types, widths and codes for the GIMP shape weight and gradient unit.
`timescale 1ns / 1ps

package gsw_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WEIGHT_FRAC   = 16;
	localparam int POS_W         = 32;
	localparam int CELL_W        = 31;
	localparam int HALF_W        = 30;
	localparam int WEIGHT_W      = 17;
	localparam int GRAD_W        = 32;
	localparam int REGION_W      = 3;
	localparam int BND_W         = 34;
	localparam int X_W           = 33;
	localparam int OPD_W         = 31;
	localparam int SQ_W          = 2 * OPD_W;
	localparam int GNUM_W        = OPD_W;
	localparam int WNUM_W        = SQ_W;
	localparam int D2_W          = CELL_W + HALF_W + 1;
	localparam int LPSQ_W        = 2 * HALF_W;
	localparam int D_W           = D2_W + 1;
	localparam int Q_W           = GRAD_W - 1;
	localparam int WN_W          = WNUM_W + WEIGHT_FRAC + 1;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = CELL_W;

	localparam logic [CELL_W-1:0]   CELL_RST   = CELL_W'(65536);
	localparam logic [HALF_W-1:0]   HALF_RST   = HALF_W'(16384);
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
	localparam logic [GRAD_W-1:0]   GRAD_MAX   = {1'b0, {(GRAD_W-1){1'b1}}};
	localparam logic [GRAD_W-1:0]   GRAD_MIN   = {1'b1, {(GRAD_W-1){1'b0}}};

	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_LENGTH = 1'b1;

	localparam logic [REGION_W-1:0] RGN_OUT    = 3'd0;
	localparam logic [REGION_W-1:0] RGN_L_TAIL = 3'd1;
	localparam logic [REGION_W-1:0] RGN_L_LIN  = 3'd2;
	localparam logic [REGION_W-1:0] RGN_CENTRE = 3'd3;
	localparam logic [REGION_W-1:0] RGN_R_LIN  = 3'd4;
	localparam logic [REGION_W-1:0] RGN_R_TAIL = 3'd5;

	typedef struct packed {
		logic                     valid;
		logic [REGION_W-1:0]      region;
		logic                     neg;
		logic                     wzero;
	} side_t;

	typedef struct packed {
		logic [CELL_W-1:0]        cell_len;
		logic                     cell_nz;
		logic signed [BND_W-1:0]  b_llp_n;
		logic signed [BND_W-1:0]  b_lml_n;
		logic signed [BND_W-1:0]  b_lp_n;
		logic signed [BND_W-1:0]  b_lp_p;
		logic signed [BND_W-1:0]  b_lml_p;
		logic signed [BND_W-1:0]  b_llp_p;
		logic [CELL_W:0]          llp;
		logic [D2_W-1:0]          d2;
		logic signed [63:0]       d2_lpsq;
	} cfg_t;

	function automatic int gn_width(input int frac);
		int w;
		w = GNUM_W + 2 * frac;
		if (w < D_W - 1) begin
			w = D_W - 1;
		end
		return w + 1;
	endfunction

endpackage

// ===== src/gsw_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps

module gsw_div #(
	parameter int N_W = gsw_pkg::WN_W,
	parameter int D_W = gsw_pkg::D_W,
	parameter int Q_W = gsw_pkg::Q_W
) (
	input  logic           clk,
	input  logic           en,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           ovf,
	output logic [Q_W-1:0] quo
);

	localparam int HI_W = N_W - Q_W;
	localparam int C_W  = (HI_W > D_W) ? HI_W : D_W;

	logic [C_W-1:0] hi_c;
	logic [C_W-1:0] den_c;

	logic [D_W-1:0] rem_s [0:Q_W-1];
	logic [Q_W-1:0] low_s [0:Q_W-1];
	logic [D_W-1:0] den_s [0:Q_W-1];
	logic [Q_W-1:0] quo_s [0:Q_W];
	logic           ovf_s [0:Q_W];

	assign hi_c  = C_W'(num[N_W-1:Q_W]);
	assign den_c = C_W'(den);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= hi_c[D_W-1:0];
			low_s[0] <= num[Q_W-1:0];
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= (hi_c >= den_c);
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_stage
		logic [D_W:0]   cat;
		logic [D_W+1:0] diff;
		logic           ge;

		always_comb begin
			cat  = {rem_s[k-1], low_s[k-1][Q_W-1]};
			diff = {1'b0, cat} - {2'b00, den_s[k-1]};
			ge   = ~diff[D_W+1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= {quo_s[k-1][Q_W-2:0], ge};
				ovf_s[k] <= ovf_s[k-1];
			end
		end

		if (k < Q_W) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[D_W-1:0] : cat[D_W-1:0];
					low_s[k] <= low_s[k-1] << 1;
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign ovf = ovf_s[Q_W];
	assign quo = quo_s[Q_W];

endmodule

// ===== src/gsw_front.sv =====
// Front stages: offset, region decode, square, numerator and divisor set-up.
`timescale 1ns / 1ps

module gsw_front #(
	parameter int FRAC_BITS = gsw_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  logic signed [gsw_pkg::POS_W-1:0]        particle_pos,
	input  logic signed [gsw_pkg::POS_W-1:0]        node_pos,
	input  gsw_pkg::cfg_t                           cfg,
	output gsw_pkg::side_t                          side_s5,
	output logic [gsw_pkg::WN_W-1:0]                wn_s5,
	output logic [gsw_pkg::D_W-1:0]                 wd_s5,
	output logic [gsw_pkg::gn_width(FRAC_BITS)-1:0] gn_s5,
	output logic [gsw_pkg::D_W-1:0]                 gd_s5
);

	import gsw_pkg::*;

	localparam int GN_W = gn_width(FRAC_BITS);

	logic                    v_s1;
	logic signed [X_W-1:0]   x_s1;

	logic signed [BND_W-1:0] xe;
	logic signed [BND_W-1:0] t1;
	logic signed [BND_W-1:0] t5;
	logic signed [BND_W-1:0] ax;
	logic signed [BND_W-1:0] lpx;
	logic signed [BND_W-1:0] lmx;
	logic                    in1, in2, in3, in4, in5;
	logic [REGION_W-1:0]     rgn;
	logic [OPD_W-1:0]        opd;
	logic [GNUM_W-1:0]       gnum;
	logic [OPD_W-1:0]        wlin;
	logic                    neg;

	side_t                   side_s2;
	logic [OPD_W-1:0]        opd_s2;
	logic [GNUM_W-1:0]       gnum_s2;
	logic [OPD_W-1:0]        wlin_s2;

	logic [SQ_W-1:0]         sq;
	side_t                   side_s3;
	logic [SQ_W-1:0]         sq_s3;
	logic [GNUM_W-1:0]       gnum_s3;
	logic [OPD_W-1:0]        wlin_s3;

	logic signed [63:0]      nr;
	logic [WNUM_W-1:0]       wnum;
	logic [D_W-1:0]          wden;
	logic [D_W-1:0]          gden;
	logic                    wzero;

	side_t                   side_s4;
	logic [WNUM_W-1:0]       wnum_s4;
	logic [D_W-1:0]          wden_s4;
	logic [GNUM_W-1:0]       gnum_s4;
	logic [D_W-1:0]          gden_s4;

	// stage 1: offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= $signed({particle_pos[POS_W-1], particle_pos})
				- $signed({node_pos[POS_W-1], node_pos});
		end
	end

	// stage 2: region decode
	always_comb begin
		xe   = {x_s1[X_W-1], x_s1};
		t1   = $signed({2'b00, cfg.llp}) + xe;
		t5   = $signed({2'b00, cfg.llp}) - xe;
		ax   = x_s1[X_W-1] ? -xe : xe;
		lpx  = $signed({3'b000, cfg.cell_len}) + xe;
		lmx  = $signed({3'b000, cfg.cell_len}) - xe;
		in1  = cfg.cell_nz && (xe > cfg.b_llp_n) && (xe <= cfg.b_lml_n);
		in2  = cfg.cell_nz && (xe > cfg.b_lml_n) && (xe <= cfg.b_lp_n);
		in3  = cfg.cell_nz && (xe > cfg.b_lp_n) && (xe <= cfg.b_lp_p);
		in4  = cfg.cell_nz && (xe > cfg.b_lp_p) && (xe <= cfg.b_lml_p);
		in5  = cfg.cell_nz && (xe > cfg.b_lml_p) && (xe <= cfg.b_llp_p);
		rgn  = RGN_OUT;
		opd  = '0;
		gnum = '0;
		wlin = '0;
		neg  = 1'b0;
		if (in1) begin
			rgn  = RGN_L_TAIL;
			opd  = t1[OPD_W-1:0];
			gnum = t1[GNUM_W-1:0];
		end else if (in2) begin
			rgn  = RGN_L_LIN;
			gnum = GNUM_W'(1);
			wlin = lpx[OPD_W-1:0];
		end else if (in3) begin
			rgn  = RGN_CENTRE;
			opd  = ax[OPD_W-1:0];
			gnum = ax[GNUM_W-1:0];
			neg  = ~x_s1[X_W-1] && (x_s1 != '0);
		end else if (in4) begin
			rgn  = RGN_R_LIN;
			gnum = GNUM_W'(1);
			wlin = lmx[OPD_W-1:0];
			neg  = 1'b1;
		end else if (in5) begin
			rgn  = RGN_R_TAIL;
			opd  = t5[OPD_W-1:0];
			gnum = t5[GNUM_W-1:0];
			neg  = 1'b1;
		end
	end

	// stage 3: square
	assign sq = opd_s2 * opd_s2;

	// stage 4: numerators and divisors per region
	always_comb begin
		nr    = cfg.d2_lpsq - $signed({2'b00, sq_s3});
		wnum  = '0;
		wden  = '0;
		gden  = '0;
		wzero = 1'b0;
		case (side_s3.region) inside
			RGN_L_TAIL, RGN_R_TAIL: begin
				wnum = sq_s3;
				wden = {cfg.d2, 1'b0};
				gden = {1'b0, cfg.d2};
			end
			RGN_L_LIN, RGN_R_LIN: begin
				wnum = WNUM_W'(wlin_s3);
				wden = D_W'(cfg.cell_len);
				gden = D_W'(cfg.cell_len);
			end
			RGN_CENTRE: begin
				wnum  = nr[WNUM_W-1:0];
				wden  = {1'b0, cfg.d2};
				gden  = {2'b00, cfg.d2[D2_W-1:1]};
				wzero = (nr <= 64'sd0);
			end
			default: begin
				wzero = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
		end else if (en) begin
			side_s2 <= '{valid: v_s1, region: rgn, neg: neg, wzero: 1'b0};
			side_s3 <= side_s2;
			side_s4 <= '{valid: side_s3.valid, region: side_s3.region,
				neg: side_s3.neg, wzero: wzero};
			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			opd_s2  <= opd;
			gnum_s2 <= gnum;
			wlin_s2 <= wlin;
			sq_s3   <= sq;
			gnum_s3 <= gnum_s2;
			wlin_s3 <= wlin_s2;
			wnum_s4 <= wnum;
			wden_s4 <= wden;
			gnum_s4 <= gnum_s3;
			gden_s4 <= gden;
			wn_s5   <= (WN_W'(wnum_s4) << WEIGHT_FRAC) + WN_W'(wden_s4 >> 1);
			wd_s5   <= wden_s4;
			gn_s5   <= (GN_W'(gnum_s4) << (2 * FRAC_BITS)) + GN_W'(gden_s4 >> 1);
			gd_s5   <= gden_s4;
		end
	end

endmodule

// ===== src/gimp_shape_weight_and_gradient_unit.sv =====
// Top level of the GIMP shape weight and gradient unit.
`timescale 1ns / 1ps
// One particle-node pair per transaction on the slave stream; one result per
// pair on the master stream, in order. Results have weight (Q1.16), gradient
// (signed, FRAC_BITS fraction bits, saturated) and the region code in tuser.
// The user writes cell size and half-length on the cfg channel only while the
// unit is idle; the block does not enforce this. Derived terms are registered.
// Path from an accepted transaction to m_tvalid: five set-up stages, the first
// loaded at the accepting edge, 32 divider stages and the output register.
// Throughput: one pair per cycle while the skid entry is empty, set by the two
// divider pipelines that retire one quotient bit per stage.
// The output register and a one-entry skid buffer decouple the sides: the
// pipeline keeps moving while a result waits, and holds only once the skid
// entry is occupied; then s_tready drops until the master takes a result.
// Reset clears all valid bits, empties the output buffer and restores cell
// size 1.0 and half-length 0.25.
module gimp_shape_weight_and_gradient_unit #(
	parameter int FRAC_BITS = gsw_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [63:0]                       s_tdata,   // particle_pos, node_pos
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [55:0]                       m_tdata,   // weight, gradient
	output logic [gsw_pkg::REGION_W-1:0]      m_tuser,   // region
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gsw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gsw_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import gsw_pkg::*;

	localparam int GN_W = gn_width(FRAC_BITS);

	localparam longint L0 = longint'(CELL_RST);
	localparam longint H0 = longint'(HALF_RST);

	localparam cfg_t DRV_RST = '{
		cell_len: CELL_RST,
		cell_nz:  1'b1,
		b_llp_n:  BND_W'(-(L0 + H0)),
		b_lml_n:  BND_W'(H0 - L0),
		b_lp_n:   BND_W'(-H0),
		b_lp_p:   BND_W'(H0),
		b_lml_p:  BND_W'(L0 - H0),
		b_llp_p:  BND_W'(L0 + H0),
		llp:      (CELL_W + 1)'(L0 + H0),
		d2:       D2_W'(2 * L0 * H0),
		d2_lpsq:  64'(2 * L0 * H0 - H0 * H0)
	};

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [GRAD_W-1:0]   gradient;
		logic [REGION_W-1:0] region;
	} res_t;

	logic [CELL_W-1:0]       cell_size_q;
	logic [HALF_W-1:0]       half_length_q;
	cfg_t                    drv_q;
	logic [LPSQ_W-1:0]       lpsq_q;
	logic [CELL_W+HALF_W-1:0] lh;
	logic [LPSQ_W-1:0]       hh;
	logic signed [BND_W-1:0] lz;
	logic signed [BND_W-1:0] hz;

	logic                    en;
	side_t                   side_s5;
	logic [WN_W-1:0]         wn_s5;
	logic [D_W-1:0]          wd_s5;
	logic [GN_W-1:0]         gn_s5;
	logic [D_W-1:0]          gd_s5;

	side_t                   dside_s [0:Q_W];
	logic                    wovf;
	logic [Q_W-1:0]          wquo;
	logic                    govf;
	logic [Q_W-1:0]          gquo;

	side_t                   fin;
	res_t                    res;
	logic                    push;
	res_t                    out_q;
	logic                    out_v_q;
	res_t                    skid_q;
	logic                    skid_v_q;

	// configuration registers and derived terms
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q   <= CELL_RST;
			half_length_q <= HALF_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CELL_SIZE:   cell_size_q   <= cfg_data;
				CFG_HALF_LENGTH: half_length_q <= cfg_data[HALF_W-1:0];
			endcase
		end
	end

	assign lh = cell_size_q * half_length_q;
	assign hh = half_length_q * half_length_q;
	assign lz = $signed(BND_W'(cell_size_q));
	assign hz = $signed(BND_W'(half_length_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_q  <= DRV_RST;
			lpsq_q <= LPSQ_W'(H0 * H0);
		end else begin
			drv_q.cell_len <= cell_size_q;
			drv_q.cell_nz  <= (cell_size_q != '0);
			drv_q.b_llp_n  <= -lz - hz;
			drv_q.b_lml_n  <= hz - lz;
			drv_q.b_lp_n   <= -hz;
			drv_q.b_lp_p   <= hz;
			drv_q.b_lml_p  <= lz - hz;
			drv_q.b_llp_p  <= lz + hz;
			drv_q.llp      <= (CELL_W + 1)'(cell_size_q) + (CELL_W + 1)'(half_length_q);
			drv_q.d2       <= {lh, 1'b0};
			drv_q.d2_lpsq  <= $signed(64'(drv_q.d2)) - $signed(64'(lpsq_q));
			lpsq_q         <= hh;
		end
	end

	// pipeline
	assign en       = ~skid_v_q;
	assign s_tready = en;

	gsw_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_tvalid),
		.particle_pos (s_tdata[31:0]),
		.node_pos     (s_tdata[63:32]),
		.cfg          (drv_q),
		.side_s5      (side_s5),
		.wn_s5        (wn_s5),
		.wd_s5        (wd_s5),
		.gn_s5        (gn_s5),
		.gd_s5        (gd_s5)
	);

	gsw_div #(
		.N_W (WN_W),
		.D_W (D_W),
		.Q_W (Q_W)
	) u_wdiv (
		.clk (clk),
		.en  (en),
		.num (wn_s5),
		.den (wd_s5),
		.ovf (wovf),
		.quo (wquo)
	);

	gsw_div #(
		.N_W (GN_W),
		.D_W (D_W),
		.Q_W (Q_W)
	) u_gdiv (
		.clk (clk),
		.en  (en),
		.num (gn_s5),
		.den (gd_s5),
		.ovf (govf),
		.quo (gquo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= Q_W; k++) begin
				dside_s[k] <= '0;
			end
		end else if (en) begin
			dside_s[0] <= side_s5;
			for (int k = 1; k <= Q_W; k++) begin
				dside_s[k] <= dside_s[k-1];
			end
		end
	end

	// clamp and saturate
	assign fin = dside_s[Q_W];

	always_comb begin
		res.region = fin.region;
		if (fin.region == RGN_OUT || fin.wzero) begin
			res.weight = '0;
		end else if (wovf || (wquo > Q_W'(WEIGHT_ONE))) begin
			res.weight = WEIGHT_ONE;
		end else begin
			res.weight = wquo[WEIGHT_W-1:0];
		end
		if (fin.region == RGN_OUT) begin
			res.gradient = '0;
		end else if (fin.neg) begin
			res.gradient = govf ? GRAD_MIN : -{1'b0, gquo};
		end else begin
			res.gradient = govf ? GRAD_MAX : {1'b0, gquo};
		end
	end

	assign push = en && fin.valid;

	// output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_tready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'b0, out_q.gradient, out_q.weight};
	assign m_tuser  = out_q.region;

endmodule

// ===== tb/tb_gimp_shape_weight_and_gradient_unit.sv =====
// Testbench for the GIMP shape weight and gradient unit: directed and random pairs checked in order.
`timescale 1ns / 1ps

module tb_gimp_shape_weight_and_gradient_unit;

	import gsw_pkg::*;

	localparam int  GRAD_SHIFT     = 2 * FRAC_BITS_DEF;
	localparam int  CFG_SETTLE     = 3;
	localparam int  END_DRAIN      = 45;
	localparam int  WATCHDOG_LIMIT = 2000;
	localparam int  LONG_HOLD      = 400;
	localparam int  MAX_REPORTS    = 60;
	localparam logic [CELL_W-1:0] CELL_TOP = '1;
	localparam logic [HALF_W-1:0] HALF_TOP = '1;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [GRAD_W-1:0]   gradient;
		logic [REGION_W-1:0] region;
	} shape_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [63:0]          s_tdata;   // particle_pos, node_pos
	logic                 m_tvalid;
	logic                 m_tready;
	logic [55:0]          m_tdata;   // weight, gradient
	logic [REGION_W-1:0]  m_tuser;   // region
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [CELL_W-1:0] cell_len = CELL_RST;
	logic [HALF_W-1:0] half_len = HALF_RST;
	shape_t            pending_shapes[$];
	int                mismatch_count = 0;
	int                quiet_cycles = 0;
	int                sink_hold_req = 0;
	bit                src_gaps_on = 1'b1;
	bit                sink_gaps_on = 1'b1;

	gimp_shape_weight_and_gradient_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// round(a*b*2^s / den), nearest with ties up, saturated to 64 bits
	function automatic logic [63:0] rounded_quot(input logic [63:0] a, input logic [63:0] b,
			input int unsigned s, input logic [63:0] den);
		logic [191:0] num;
		logic [191:0] q;
		num = ({128'd0, a} * {128'd0, b}) << s;
		num = num + {129'd0, den[63:1]};
		q = num / {128'd0, den};
		return (q[191:64] != 0) ? '1 : q[63:0];
	endfunction

	function automatic shape_t gimp_shape(input logic [POS_W-1:0] particle,
			input logic [POS_W-1:0] node);
		longint      x, cl, hl, d2, wn;
		logic [63:0] w, gmag, t;
		logic        neg;
		shape_t      r;
		x = longint'($signed(particle)) - longint'($signed(node));
		cl = longint'({33'd0, cell_len});
		hl = longint'({34'd0, half_len});
		d2 = 2 * cl * hl;
		w = 0;
		gmag = 0;
		neg = 1'b0;
		r.region = RGN_OUT;
		if (cl != 0) begin
			if (-cl - hl < x && x <= -cl + hl) begin
				t = cl + hl + x;
				r.region = RGN_L_TAIL;
				w = rounded_quot(t, t, WEIGHT_FRAC, 2 * d2);
				gmag = rounded_quot(t, 1, GRAD_SHIFT, d2);
			end else if (-cl + hl < x && x <= -hl) begin
				r.region = RGN_L_LIN;
				w = rounded_quot(cl + x, 1, WEIGHT_FRAC, cl);
				gmag = rounded_quot(1, 1, GRAD_SHIFT, cl);
			end else if (-hl < x && x <= hl) begin
				wn = d2 - x * x - hl * hl;
				r.region = RGN_CENTRE;
				w = (wn > 0) ? rounded_quot(wn, 1, WEIGHT_FRAC, d2) : 64'd0;
				neg = x > 0;
				gmag = rounded_quot((x < 0) ? -x : x, 1, GRAD_SHIFT, d2 >>> 1);
			end else if (hl < x && x <= cl - hl) begin
				r.region = RGN_R_LIN;
				w = rounded_quot(cl - x, 1, WEIGHT_FRAC, cl);
				gmag = rounded_quot(1, 1, GRAD_SHIFT, cl);
				neg = 1'b1;
			end else if (cl - hl < x && x <= cl + hl) begin
				t = cl + hl - x;
				r.region = RGN_R_TAIL;
				w = rounded_quot(t, t, WEIGHT_FRAC, 2 * d2);
				gmag = rounded_quot(t, 1, GRAD_SHIFT, d2);
				neg = 1'b1;
			end
		end
		r.weight = (w > 64'(WEIGHT_ONE)) ? WEIGHT_ONE : w[WEIGHT_W-1:0];
		if (neg) begin
			r.gradient = (gmag >= 64'h8000_0000) ? GRAD_MIN : -gmag[GRAD_W-1:0];
		end else begin
			r.gradient = (gmag > 64'h7fff_ffff) ? GRAD_MAX : gmag[GRAD_W-1:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatch_count < MAX_REPORTS) begin
			$display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
		end
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		shape_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_shapes.size() == 0) begin
				report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
			end else begin
				want = pending_shapes.pop_front();
				if (m_tdata[WEIGHT_W-1:0] !== want.weight)
					report_mismatch("weight", 64'(m_tdata[WEIGHT_W-1:0]), 64'(want.weight));
				if (m_tdata[WEIGHT_W +: GRAD_W] !== want.gradient)
					report_mismatch("gradient", 64'(m_tdata[WEIGHT_W +: GRAD_W]),
						64'(want.gradient));
				if (m_tuser !== want.region)
					report_mismatch("region", 64'(m_tuser), 64'(want.region));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = sink_gaps_on ? $urandom_range(0, 6) : 0;
			if (sink_hold_req != 0) begin
				stall = sink_hold_req;
				sink_hold_req = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_shapes.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_CELL_SIZE) begin
			cell_len = val;
		end else begin
			half_len = val[HALF_W-1:0];
		end
		repeat (CFG_SETTLE) @(negedge clk);
	endtask

	task automatic set_shape(input logic [CELL_W-1:0] cell_val, input logic [HALF_W-1:0] half);
		write_reg(CFG_CELL_SIZE, cell_val);
		write_reg(CFG_HALF_LENGTH, CFG_DATA_W'(half));
	endtask

	task automatic send_pair(input logic [POS_W-1:0] particle, input logic [POS_W-1:0] node);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {node, particle};
		do @(posedge clk); while (!s_tready);
		pending_shapes.push_back(gimp_shape(particle, node));
		@(negedge clk);
	endtask

	function automatic longint support_edge(input int k);
		longint cl, hl;
		cl = longint'({33'd0, cell_len});
		hl = longint'({34'd0, half_len});
		case (k)
			0: return -cl - hl;
			1: return -cl + hl;
			2: return -hl;
			3: return hl;
			4: return cl - hl;
			default: return cl + hl;
		endcase
	endfunction

	task automatic send_offset(input longint off);
		logic [POS_W-1:0] node;
		node = $urandom;
		send_pair(node + off[POS_W-1:0], node);
	endtask

	task automatic send_random_pairs(input int count);
		longint span, off;
		logic [63:0] r;
		int pick;
		repeat (count) begin
			span = longint'({33'd0, cell_len}) + longint'({34'd0, half_len}) + 2;
			pick = $urandom_range(0, 19);
			if (pick < 3) begin
				send_pair($urandom, $urandom);
			end else begin
				if (pick < 10) begin
					off = support_edge($urandom_range(0, 5)) + $urandom_range(0, 4) - 2;
				end else begin
					r = {$urandom, $urandom};
					off = longint'(r[61:0]) % (2 * span + 1) - span;
				end
				send_offset(off);
			end
		end
	endtask

	task automatic test_boundaries();
		for (int k = 0; k < 6; k++) begin
			send_offset(support_edge(k));
			send_offset(support_edge(k) + 1);
		end
		send_offset(0);
	endtask

	task automatic test_field_extremes();
		send_pair(32'h7fff_ffff, 32'h8000_0000);
		send_pair(32'h8000_0000, 32'h7fff_ffff);
		send_pair(32'h0000_0000, 32'h0000_0000);
		send_pair(32'h8000_0000, 32'h8000_0000);
		send_pair(32'hffff_ffff, 32'h7fff_ffff);
	endtask

	task automatic test_zero_cell();
		set_shape('0, HALF_RST);
		send_random_pairs(60);
	endtask

	task automatic test_zero_half_length();
		set_shape(CELL_RST, '0);
		send_random_pairs(100);
	endtask

	task automatic test_overlap();
		set_shape(CELL_RST, 30'd50000);
		send_random_pairs(80);
		set_shape(31'd100, HALF_TOP);
		send_random_pairs(70);
	endtask

	task automatic test_gradient_saturation();
		set_shape(31'd1, 30'd1);
		send_random_pairs(60);
		set_shape(31'd3, 30'd1);
		send_random_pairs(60);
	endtask

	task automatic test_largest_cell();
		set_shape(CELL_TOP, HALF_TOP);
		send_random_pairs(120);
	endtask

	task automatic test_random_settings();
		logic [CELL_W-1:0] cell_val;
		logic [HALF_W-1:0] half;
		for (int n = 0; n < 6; n++) begin
			cell_val = CELL_W'($urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 28));
			if (cell_val == 0) cell_val = 1;
			if ($urandom_range(0, 4) == 0) begin
				half = HALF_W'($urandom >> $urandom_range(2, 31));
			end else begin
				half = HALF_W'($urandom_range(0, 32'(cell_val) >> 1));
			end
			src_gaps_on = (n % 3) != 1;
			sink_gaps_on = (n % 3) != 2;
			set_shape(cell_val, half);
			send_random_pairs(100);
		end
		src_gaps_on = 1'b1;
		sink_gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		set_shape(CELL_RST, HALF_RST);
		src_gaps_on = 1'b0;
		sink_hold_req = LONG_HOLD;
		send_random_pairs(150);
		src_gaps_on = 1'b1;
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CELL_SIZE;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_boundaries();
		test_field_extremes();
		test_zero_cell();
		test_zero_half_length();
		test_overlap();
		test_gradient_saturation();
		test_largest_cell();
		test_random_settings();
		test_backpressure();
		wait_idle();
		repeat (END_DRAIN) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== gimp_shape_weight_and_gradient_unit.f =====
src/gsw_pkg.sv
src/gsw_div.sv
src/gsw_front.sv
src/gimp_shape_weight_and_gradient_unit.sv
tb/tb_gimp_shape_weight_and_gradient_unit.sv
